// File: hdl/hdl_source_tokenizer_core_defines.svh
// Assertion macros shared by the tokenizer checker.
`ifndef HDL_SOURCE_TOKENIZER_CORE_DEFINES_SVH
`define HDL_SOURCE_TOKENIZER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, masked while in reset.
`define HST_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer check failed");

// Next-cycle implication, sampled on clk, masked while in reset.
`define HST_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer check failed");

`endif

// File: hdl/hst_pkg.sv
// Types, codes and character constants of the source tokenizer.
package hst_pkg;

    // input item as seen on the push side
    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_input;
    } item_t;

    // result item as seen on the pop side
    typedef struct packed {
        logic [1:0] event_kind;
        logic [7:0] char_out;
        logic [4:0] token_type;
        logic       last_of_run;
    } result_t;

    // byte after classification by the front end
    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_input;
        logic       is_zero;
        logic       is_ws;
        logic       is_alnum;
        logic [4:0] punct;      // TT_UNKNOWN when not punctuation
    } cls_t;

    // up to two results written to the result queue in one cycle
    typedef struct packed {
        logic [1:0] n;
        result_t    r0;
        result_t    r1;
    } res_wr_t;

    // event kinds
    localparam logic [1:0] EV_APPEND = 2'd0;
    localparam logic [1:0] EV_FINISH = 2'd1;
    localparam logic [1:0] EV_ERROR  = 2'd2;

    // token types
    localparam logic [4:0] TT_UNKNOWN  = 5'd0;
    localparam logic [4:0] TT_COMMENT  = 5'd1;
    localparam logic [4:0] TT_CHIP     = 5'd2;
    localparam logic [4:0] TT_IN       = 5'd3;
    localparam logic [4:0] TT_OUT      = 5'd4;
    localparam logic [4:0] TT_PARTS    = 5'd5;
    localparam logic [4:0] TT_SYMBOL   = 5'd6;
    localparam logic [4:0] TT_RANGE    = 5'd7;
    localparam logic [4:0] TT_LPAREN   = 5'd8;
    localparam logic [4:0] TT_RPAREN   = 5'd9;
    localparam logic [4:0] TT_LBRACE   = 5'd10;
    localparam logic [4:0] TT_RBRACE   = 5'd11;
    localparam logic [4:0] TT_LBRACKET = 5'd12;
    localparam logic [4:0] TT_RBRACKET = 5'd13;
    localparam logic [4:0] TT_COMMA    = 5'd14;
    localparam logic [4:0] TT_EQUALS   = 5'd15;
    localparam logic [4:0] TT_COLON    = 5'd16;
    localparam logic [4:0] TT_SEMI     = 5'd17;
    localparam logic [4:0] TT_END      = 5'd18;

    // characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UC    = 8'h43;
    localparam logic [7:0] CH_UH    = 8'h48;
    localparam logic [7:0] CH_UI    = 8'h49;
    localparam logic [7:0] CH_UN    = 8'h4E;
    localparam logic [7:0] CH_UO    = 8'h4F;
    localparam logic [7:0] CH_UP    = 8'h50;
    localparam logic [7:0] CH_UR    = 8'h52;
    localparam logic [7:0] CH_US    = 8'h53;
    localparam logic [7:0] CH_UT    = 8'h54;
    localparam logic [7:0] CH_UU    = 8'h55;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_LBRC  = 8'h7B;
    localparam logic [7:0] CH_RBRC  = 8'h7D;

endpackage

// File: hdl/hdl_source_tokenizer_core.sv
// Top level of the source tokenizer: front end, lexer and result queue.
//
//  channel   handshake         payload            transfer when
//  -------   ---------------   ----------------   ---------------------
//  input     push / full       item   (item_t)    push && !full
//  result    empty / pop       result (result_t)  pop && !empty
//
// One byte per cycle while the result queue has room and each byte yields one
// result at most; a byte that closes a token and starts the next yields two,
// and the one-per-cycle pop port then paces that byte. A first result passes
// the registered front queue, then is lexed into the registered result queue.
// rst_n clears the queues and the lexer; a syntax error silences the block
// until reset. Lexer stalls while three or more results wait; front buffers two.
module hdl_source_tokenizer_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  hst_pkg::item_t   item,
    output logic             empty,
    input  logic             pop,
    output hst_pkg::result_t result
);

    logic             cls_valid;
    logic             cls_ready;
    hst_pkg::cls_t    cls;
    logic             room;
    hst_pkg::res_wr_t res_wr;

    // byte classification and input buffering
    hst_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cls_valid (cls_valid),
        .cls_ready (cls_ready),
        .cls       (cls)
    );

    // character state machine; stalls only when the result queue lacks room
    hst_lexer u_lexer (
        .clk       (clk),
        .rst_n     (rst_n),
        .cls_valid (cls_valid),
        .cls_ready (cls_ready),
        .cls       (cls),
        .room      (room),
        .res_wr    (res_wr)
    );

    // results wait here for the consumer
    hst_result_queue u_result_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .res_wr (res_wr),
        .room   (room),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

endmodule

// File: hdl/hst_front.sv
// Front end: takes source bytes, classifies them and holds them in a two-entry queue.
module hst_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  hst_pkg::item_t item,
    output logic           cls_valid,
    input  logic           cls_ready,
    output hst_pkg::cls_t  cls
);

    function automatic logic is_ws(input logic [7:0] c);
        is_ws = (c == hst_pkg::CH_SPACE) || (c == hst_pkg::CH_TAB) || (c == hst_pkg::CH_NL)
             || (c == hst_pkg::CH_VT) || (c == hst_pkg::CH_FF) || (c == hst_pkg::CH_CR);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        is_alnum = (c >= hst_pkg::CH_LA && c <= hst_pkg::CH_LZ)
                || (c >= hst_pkg::CH_UA && c <= hst_pkg::CH_UZ)
                || (c >= hst_pkg::CH_0 && c <= hst_pkg::CH_9);
    endfunction

    function automatic logic [4:0] punct_code(input logic [7:0] c);
        case (c)
            hst_pkg::CH_LPAR:  punct_code = hst_pkg::TT_LPAREN;
            hst_pkg::CH_RPAR:  punct_code = hst_pkg::TT_RPAREN;
            hst_pkg::CH_LBRC:  punct_code = hst_pkg::TT_LBRACE;
            hst_pkg::CH_RBRC:  punct_code = hst_pkg::TT_RBRACE;
            hst_pkg::CH_LBRK:  punct_code = hst_pkg::TT_LBRACKET;
            hst_pkg::CH_RBRK:  punct_code = hst_pkg::TT_RBRACKET;
            hst_pkg::CH_COMMA: punct_code = hst_pkg::TT_COMMA;
            hst_pkg::CH_EQ:    punct_code = hst_pkg::TT_EQUALS;
            hst_pkg::CH_COLON: punct_code = hst_pkg::TT_COLON;
            hst_pkg::CH_SEMI:  punct_code = hst_pkg::TT_SEMI;
            default:           punct_code = hst_pkg::TT_UNKNOWN;
        endcase
    endfunction

    hst_pkg::cls_t q_reg [2];
    hst_pkg::cls_t cls_in;
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    logic          wr_en, rd_en;

    always_comb
    begin
        cls_in.char_in      = item.char_in;
        cls_in.end_of_input = item.end_of_input;
        cls_in.is_zero      = (item.char_in == hst_pkg::CH_NUL);
        cls_in.is_ws        = is_ws(item.char_in);
        cls_in.is_alnum     = is_alnum(item.char_in);
        cls_in.punct        = punct_code(item.char_in);
    end

    assign full      = (count_reg == 2'd2);
    assign cls_valid = (count_reg != 2'd0);
    assign cls       = q_reg[rd_ptr_reg];
    assign wr_en     = push && !full;
    assign rd_en     = cls_valid && cls_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ wr_en;
        rd_ptr_next = rd_ptr_reg ^ rd_en;
        count_next  = count_reg + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_reg[wr_ptr_reg] <= cls_in;
        end
    end

endmodule

// File: hdl/hst_lexer.sv
// Back end: lexer state machine, up to two results per classified byte.
module hst_lexer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cls_valid,
    output logic             cls_ready,
    input  hst_pkg::cls_t    cls,
    input  logic             room,
    output hst_pkg::res_wr_t res_wr
);

    typedef enum logic [4:0] {
        ST_NEW,
        ST_COMPLETE,
        ST_WS,
        ST_SLASH,
        ST_LINE,
        ST_MULTI,
        ST_TERM,
        ST_CHIP_C,
        ST_CHIP_H,
        ST_CHIP_I,
        ST_IN_I,
        ST_OUT_O,
        ST_OUT_U,
        ST_PARTS_P,
        ST_PARTS_A,
        ST_PARTS_R,
        ST_PARTS_T,
        ST_DOT,
        ST_STRING
    } state_t;

    state_t           state_reg, state_next;
    logic [4:0]       type_reg, type_next;
    logic             nonempty_reg, nonempty_next;
    logic             halt_reg, halt_next;

    logic             take;
    logic             go_new;
    logic             a_v, b_v;
    hst_pkg::result_t a_res, b_res;
    logic             kw;
    logic [7:0]       kw_want;
    state_t           kw_next;
    logic [4:0]       kw_close;
    logic [4:0]       end_type;
    logic [7:0]       c;

    function automatic hst_pkg::result_t mk(input logic [1:0] k, input logic [7:0] ch,
                                            input logic [4:0] t);
        hst_pkg::result_t r;
        r.event_kind  = k;
        r.char_out    = ch;
        r.token_type  = t;
        r.last_of_run = 1'b0;
        mk = r;
    endfunction

    assign cls_ready = room;
    assign take      = cls_valid && room;
    assign c         = cls.char_in;
    assign end_type  = (type_reg == hst_pkg::TT_UNKNOWN && !nonempty_reg)
                     ? hst_pkg::TT_END : type_reg;

    always_comb
    begin
        state_next    = state_reg;
        type_next     = type_reg;
        nonempty_next = nonempty_reg;
        halt_next     = halt_reg;
        go_new        = 1'b0;
        a_v           = 1'b0;
        b_v           = 1'b0;
        a_res         = '0;
        b_res         = '0;
        kw            = 1'b0;
        kw_want       = hst_pkg::CH_NUL;
        kw_next       = ST_NEW;
        kw_close      = hst_pkg::TT_UNKNOWN;

        if (take && !halt_reg)
        begin
            if (cls.end_of_input)
            begin
                // flush: one finished token, then back to the reset state
                b_v           = 1'b1;
                b_res         = mk(hst_pkg::EV_FINISH, hst_pkg::CH_NUL, end_type);
                state_next    = ST_NEW;
                type_next     = hst_pkg::TT_UNKNOWN;
                nonempty_next = 1'b0;
            end
            else if (!cls.is_zero)
            begin
                case (state_reg)
                    ST_NEW:
                    begin
                        go_new = 1'b1;
                    end
                    ST_COMPLETE:
                    begin
                        a_v    = 1'b1;
                        a_res  = mk(hst_pkg::EV_FINISH, hst_pkg::CH_NUL, type_reg);
                        go_new = 1'b1;
                    end
                    ST_WS:
                    begin
                        go_new = !cls.is_ws;
                    end
                    ST_SLASH:
                    begin
                        if (c == hst_pkg::CH_SLASH)
                        begin
                            type_next  = hst_pkg::TT_COMMENT;
                            state_next = ST_LINE;
                        end
                        else if (c == hst_pkg::CH_STAR)
                        begin
                            type_next  = hst_pkg::TT_COMMENT;
                            state_next = ST_MULTI;
                        end
                        else
                        begin
                            b_v       = 1'b1;
                            b_res     = mk(hst_pkg::EV_ERROR, c, hst_pkg::TT_UNKNOWN);
                            halt_next = 1'b1;
                        end
                    end
                    ST_LINE:
                    begin
                        b_v = 1'b1;
                        if (c == hst_pkg::CH_NL)
                        begin
                            b_res         = mk(hst_pkg::EV_FINISH, hst_pkg::CH_NUL, type_reg);
                            type_next     = hst_pkg::TT_UNKNOWN;
                            nonempty_next = 1'b0;
                            state_next    = ST_NEW;
                        end
                        else
                        begin
                            b_res = mk(hst_pkg::EV_APPEND, c, hst_pkg::TT_UNKNOWN);
                        end
                    end
                    ST_MULTI:
                    begin
                        b_v   = 1'b1;
                        b_res = mk(hst_pkg::EV_APPEND, c, hst_pkg::TT_UNKNOWN);
                        if (c == hst_pkg::CH_STAR)
                        begin
                            state_next = ST_TERM;
                        end
                    end
                    ST_TERM:
                    begin
                        if (c == hst_pkg::CH_SLASH)
                        begin
                            state_next = ST_COMPLETE;
                        end
                        else
                        begin
                            b_v        = 1'b1;
                            b_res      = mk(hst_pkg::EV_APPEND, c, hst_pkg::TT_UNKNOWN);
                            state_next = ST_MULTI;
                        end
                    end
                    ST_CHIP_C:
                    begin
                        kw = 1'b1; kw_want = hst_pkg::CH_UH; kw_next = ST_CHIP_H;
                    end
                    ST_CHIP_H:
                    begin
                        kw = 1'b1; kw_want = hst_pkg::CH_UI; kw_next = ST_CHIP_I;
                    end
                    ST_CHIP_I:
                    begin
                        kw = 1'b1; kw_want = hst_pkg::CH_UP; kw_close = hst_pkg::TT_CHIP;
                    end
                    ST_IN_I:
                    begin
                        kw = 1'b1; kw_want = hst_pkg::CH_UN; kw_close = hst_pkg::TT_IN;
                    end
                    ST_OUT_O:
                    begin
                        kw = 1'b1; kw_want = hst_pkg::CH_UU; kw_next = ST_OUT_U;
                    end
                    ST_OUT_U:
                    begin
                        kw = 1'b1; kw_want = hst_pkg::CH_UT; kw_close = hst_pkg::TT_OUT;
                    end
                    ST_PARTS_P:
                    begin
                        kw = 1'b1; kw_want = hst_pkg::CH_UA; kw_next = ST_PARTS_A;
                    end
                    ST_PARTS_A:
                    begin
                        kw = 1'b1; kw_want = hst_pkg::CH_UR; kw_next = ST_PARTS_R;
                    end
                    ST_PARTS_R:
                    begin
                        kw = 1'b1; kw_want = hst_pkg::CH_UT; kw_next = ST_PARTS_T;
                    end
                    ST_PARTS_T:
                    begin
                        kw = 1'b1; kw_want = hst_pkg::CH_US; kw_close = hst_pkg::TT_PARTS;
                    end
                    ST_DOT:
                    begin
                        b_v = 1'b1;
                        if (c == hst_pkg::CH_DOT)
                        begin
                            b_res      = mk(hst_pkg::EV_APPEND, c, hst_pkg::TT_UNKNOWN);
                            type_next  = hst_pkg::TT_RANGE;
                            state_next = ST_COMPLETE;
                        end
                        else
                        begin
                            b_res     = mk(hst_pkg::EV_ERROR, c, hst_pkg::TT_UNKNOWN);
                            halt_next = 1'b1;
                        end
                    end
                    ST_STRING:
                    begin
                        if (cls.is_alnum)
                        begin
                            b_v   = 1'b1;
                            b_res = mk(hst_pkg::EV_APPEND, c, hst_pkg::TT_UNKNOWN);
                        end
                        else
                        begin
                            a_v    = 1'b1;
                            a_res  = mk(hst_pkg::EV_FINISH, hst_pkg::CH_NUL, type_reg);
                            go_new = 1'b1;
                        end
                    end
                    default:
                    begin
                        go_new = 1'b1;
                    end
                endcase

                // a closed token clears the type before the byte starts a new one
                if (a_v)
                begin
                    type_next     = hst_pkg::TT_UNKNOWN;
                    nonempty_next = 1'b0;
                end

                if (kw)
                begin
                    b_v   = 1'b1;
                    b_res = mk(hst_pkg::EV_APPEND, c, hst_pkg::TT_UNKNOWN);
                    if (c == kw_want)
                    begin
                        if (kw_close != hst_pkg::TT_UNKNOWN)
                        begin
                            type_next  = kw_close;
                            state_next = ST_COMPLETE;
                        end
                        else
                        begin
                            state_next = kw_next;
                        end
                    end
                    else
                    begin
                        type_next  = hst_pkg::TT_SYMBOL;
                        state_next = ST_STRING;
                    end
                end

                if (go_new)
                begin
                    if (cls.is_ws)
                    begin
                        state_next = ST_WS;
                    end
                    else if (c == hst_pkg::CH_SLASH)
                    begin
                        state_next = ST_SLASH;
                    end
                    else
                    begin
                        b_v   = 1'b1;
                        b_res = mk(hst_pkg::EV_APPEND, c, hst_pkg::TT_UNKNOWN);
                        if (c == hst_pkg::CH_DOT)
                        begin
                            state_next = ST_DOT;
                        end
                        else if (c == hst_pkg::CH_UC)
                        begin
                            state_next = ST_CHIP_C;
                        end
                        else if (c == hst_pkg::CH_UI)
                        begin
                            state_next = ST_IN_I;
                        end
                        else if (c == hst_pkg::CH_UO)
                        begin
                            state_next = ST_OUT_O;
                        end
                        else if (c == hst_pkg::CH_UP)
                        begin
                            state_next = ST_PARTS_P;
                        end
                        else if (cls.punct != hst_pkg::TT_UNKNOWN)
                        begin
                            type_next  = cls.punct;
                            state_next = ST_COMPLETE;
                        end
                        else if (cls.is_alnum)
                        begin
                            type_next  = hst_pkg::TT_SYMBOL;
                            state_next = ST_STRING;
                        end
                        else
                        begin
                            b_res     = mk(hst_pkg::EV_ERROR, c, hst_pkg::TT_UNKNOWN);
                            halt_next = 1'b1;
                        end
                    end
                end

                if (b_v && b_res.event_kind == hst_pkg::EV_APPEND)
                begin
                    nonempty_next = 1'b1;
                end
            end
        end
    end

    // pack: closing result first, last one flagged
    always_comb
    begin
        res_wr = '0;
        if (a_v)
        begin
            res_wr.r0             = a_res;
            res_wr.r1             = b_res;
            res_wr.n              = b_v ? 2'd2 : 2'd1;
            res_wr.r0.last_of_run = !b_v;
            res_wr.r1.last_of_run = b_v;
        end
        else if (b_v)
        begin
            res_wr.r0             = b_res;
            res_wr.n              = 2'd1;
            res_wr.r0.last_of_run = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_NEW;
            type_reg     <= hst_pkg::TT_UNKNOWN;
            nonempty_reg <= 1'b0;
            halt_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            type_reg     <= type_next;
            nonempty_reg <= nonempty_next;
            halt_reg     <= halt_next;
        end
    end

endmodule

// File: hdl/hst_result_queue.sv
// Four-entry result queue: up to two writes and one read per cycle.
module hst_result_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  hst_pkg::res_wr_t res_wr,
    output logic             room,
    output logic             empty,
    input  logic             pop,
    output hst_pkg::result_t result
);

    hst_pkg::result_t q_reg [4];
    logic [1:0]       wr_ptr_reg, wr_ptr_next;
    logic [1:0]       rd_ptr_reg, rd_ptr_next;
    logic [2:0]       count_reg, count_next;
    logic             rd_en;

    assign empty  = (count_reg == 3'd0);
    assign room   = (count_reg <= 3'd2);   // space for a two-result item
    assign result = q_reg[rd_ptr_reg];
    assign rd_en  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + res_wr.n;
        rd_ptr_next = rd_ptr_reg + {1'b0, rd_en};
        count_next  = count_reg + {1'b0, res_wr.n} - {2'b00, rd_en};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_wr.n != 2'd0)
        begin
            q_reg[wr_ptr_reg] <= res_wr.r0;
        end
        if (res_wr.n == 2'd2)
        begin
            q_reg[wr_ptr_reg + 2'd1] <= res_wr.r1;
        end
    end

endmodule

// File: hdl/hst_checker.sv
// Port-level checks on the tokenizer top level, bound in below.
`include "hdl_source_tokenizer_core_defines.svh"

module hst_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             empty,
    input logic             pop,
    input hst_pkg::result_t result
);

    // a waiting result stays until it is popped
    `HST_ASSERT_NEXT(a_hold_nonempty, !empty && !pop, !empty)
    `HST_ASSERT_NEXT(a_hold_result, !empty && !pop, $stable(result))

    // a finished token carries no byte
    `HST_ASSERT_NOW(a_finish_no_char, !empty && result.event_kind == hst_pkg::EV_FINISH,
                    result.char_out == hst_pkg::CH_NUL)

    // nothing follows a syntax error in the same run
    `HST_ASSERT_NOW(a_error_last, !empty && result.event_kind == hst_pkg::EV_ERROR,
                    result.last_of_run)

endmodule

bind hdl_source_tokenizer_core hst_checker u_checker (.*);

// File: sim/token_stream_checker.sv
// Tokenizer checker: predicts the lexer results of each transfer and compares them on pop.
`timescale 1ns / 100ps

module token_stream_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic             full,
    input  hst_pkg::item_t   item,
    input  logic             empty,
    input  logic             pop,
    input  hst_pkg::result_t result,
    output int unsigned      mismatches,
    output int unsigned      outstanding
);

    import hst_pkg::*;

    typedef enum logic [4:0] {
        LX_NEW,
        LX_COMPLETE,
        LX_WS,
        LX_SLASH,
        LX_LINE,
        LX_MULTI,
        LX_TERM,
        LX_CHIP_C,
        LX_CHIP_H,
        LX_CHIP_I,
        LX_IN_I,
        LX_OUT_O,
        LX_OUT_U,
        LX_PARTS_P,
        LX_PARTS_A,
        LX_PARTS_R,
        LX_PARTS_T,
        LX_DOT,
        LX_SYMBOL
    } lex_state_t;

    lex_state_t lx_state;
    logic [4:0] tok_type;
    logic       tok_nonempty;
    logic       halted;

    // results of the byte being lexed, then the ones still due on the pop side
    result_t    step_buf [2];
    int         step_count;
    result_t    due_results [$];

    function automatic logic is_space(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_VT ||
               c == CH_FF || c == CH_CR;
    endfunction

    function automatic logic is_word_char(logic [7:0] c);
        return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ) ||
               (c >= CH_0 && c <= CH_9);
    endfunction

    function automatic logic [4:0] punct_code(logic [7:0] c);
        case (c)
            CH_LPAR:  return TT_LPAREN;
            CH_RPAR:  return TT_RPAREN;
            CH_LBRC:  return TT_LBRACE;
            CH_RBRC:  return TT_RBRACE;
            CH_LBRK:  return TT_LBRACKET;
            CH_RBRK:  return TT_RBRACKET;
            CH_COMMA: return TT_COMMA;
            CH_EQ:    return TT_EQUALS;
            CH_COLON: return TT_COLON;
            CH_SEMI:  return TT_SEMI;
            default:  return TT_UNKNOWN;
        endcase
    endfunction

    function automatic void clear_lexer();
        lx_state     = LX_NEW;
        tok_type     = TT_UNKNOWN;
        tok_nonempty = 1'b0;
        halted       = 1'b0;
    endfunction

    function automatic void note_result(logic [1:0] kind, logic [7:0] ch, logic [4:0] tt);
        result_t r;
        if (step_count < 2)
        begin
            r.event_kind  = kind;
            r.char_out    = ch;
            r.token_type  = tt;
            r.last_of_run = 1'b0;
            step_buf[step_count] = r;
            step_count++;
        end
    endfunction

    function automatic void add_char(logic [7:0] c);
        note_result(EV_APPEND, c, TT_UNKNOWN);
        tok_nonempty = 1'b1;
    endfunction

    function automatic void close_token(logic [4:0] tt);
        note_result(EV_FINISH, CH_NUL, tt);
        tok_type     = TT_UNKNOWN;
        tok_nonempty = 1'b0;
    endfunction

    function automatic void raise_error(logic [7:0] c);
        note_result(EV_ERROR, c, TT_UNKNOWN);
        halted = 1'b1;
    endfunction

    // done_type of TT_UNKNOWN: more letters of the keyword to come
    function automatic void keyword_step(logic [7:0] c, logic [7:0] want, lex_state_t next,
                                         logic [4:0] done_type);
        add_char(c);
        if (c == want)
        begin
            if (done_type != TT_UNKNOWN)
            begin
                tok_type = done_type;
                lx_state = LX_COMPLETE;
            end
            else
                lx_state = next;
        end
        else
        begin
            tok_type = TT_SYMBOL;
            lx_state = LX_SYMBOL;
        end
    endfunction

    // a byte may pass through a few states before it is consumed
    function automatic void lex_byte(logic [7:0] c);
        logic       taken;
        logic [4:0] p;
        int         pass;
        taken = 1'b0;
        for (pass = 0; pass < 6 && !taken && !halted; pass++)
        begin
            case (lx_state)
                LX_NEW:
                begin
                    p     = punct_code(c);
                    taken = 1'b1;
                    if (is_space(c))
                        lx_state = LX_WS;
                    else if (c == CH_DOT)
                    begin
                        add_char(c);
                        lx_state = LX_DOT;
                    end
                    else if (c == CH_SLASH)
                        lx_state = LX_SLASH;
                    else if (c == CH_UC)
                    begin
                        add_char(c);
                        lx_state = LX_CHIP_C;
                    end
                    else if (c == CH_UI)
                    begin
                        add_char(c);
                        lx_state = LX_IN_I;
                    end
                    else if (c == CH_UO)
                    begin
                        add_char(c);
                        lx_state = LX_OUT_O;
                    end
                    else if (c == CH_UP)
                    begin
                        add_char(c);
                        lx_state = LX_PARTS_P;
                    end
                    else if (p != TT_UNKNOWN)
                    begin
                        add_char(c);
                        tok_type = p;
                        lx_state = LX_COMPLETE;
                    end
                    else if (is_word_char(c))
                    begin
                        tok_type = TT_SYMBOL;
                        lx_state = LX_SYMBOL;
                        taken    = 1'b0;
                    end
                    else
                        raise_error(c);
                end
                LX_COMPLETE:
                begin
                    close_token(tok_type);
                    lx_state = LX_NEW;
                end
                LX_WS:
                begin
                    if (is_space(c))
                        taken = 1'b1;
                    else
                        lx_state = LX_NEW;
                end
                LX_SLASH:
                begin
                    taken = 1'b1;
                    if (c == CH_SLASH)
                    begin
                        tok_type = TT_COMMENT;
                        lx_state = LX_LINE;
                    end
                    else if (c == CH_STAR)
                    begin
                        tok_type = TT_COMMENT;
                        lx_state = LX_MULTI;
                    end
                    else
                        raise_error(c);
                end
                LX_LINE:
                begin
                    taken = 1'b1;
                    if (c == CH_NL)
                    begin
                        close_token(tok_type);
                        lx_state = LX_NEW;
                    end
                    else
                        add_char(c);
                end
                LX_MULTI:
                begin
                    taken    = 1'b1;
                    lx_state = (c == CH_STAR) ? LX_TERM : LX_MULTI;
                    add_char(c);
                end
                LX_TERM:
                begin
                    taken = 1'b1;
                    if (c == CH_SLASH)
                        lx_state = LX_COMPLETE;
                    else
                    begin
                        add_char(c);
                        lx_state = LX_MULTI;
                    end
                end
                LX_CHIP_C:  begin taken = 1'b1; keyword_step(c, CH_UH, LX_CHIP_H, TT_UNKNOWN); end
                LX_CHIP_H:  begin taken = 1'b1; keyword_step(c, CH_UI, LX_CHIP_I, TT_UNKNOWN); end
                LX_CHIP_I:  begin taken = 1'b1; keyword_step(c, CH_UP, LX_COMPLETE, TT_CHIP); end
                LX_IN_I:    begin taken = 1'b1; keyword_step(c, CH_UN, LX_COMPLETE, TT_IN); end
                LX_OUT_O:   begin taken = 1'b1; keyword_step(c, CH_UU, LX_OUT_U, TT_UNKNOWN); end
                LX_OUT_U:   begin taken = 1'b1; keyword_step(c, CH_UT, LX_COMPLETE, TT_OUT); end
                LX_PARTS_P: begin taken = 1'b1; keyword_step(c, CH_UA, LX_PARTS_A, TT_UNKNOWN); end
                LX_PARTS_A: begin taken = 1'b1; keyword_step(c, CH_UR, LX_PARTS_R, TT_UNKNOWN); end
                LX_PARTS_R: begin taken = 1'b1; keyword_step(c, CH_UT, LX_PARTS_T, TT_UNKNOWN); end
                LX_PARTS_T: begin taken = 1'b1; keyword_step(c, CH_US, LX_COMPLETE, TT_PARTS); end
                LX_DOT:
                begin
                    taken = 1'b1;
                    if (c == CH_DOT)
                    begin
                        add_char(c);
                        tok_type = TT_RANGE;
                        lx_state = LX_COMPLETE;
                    end
                    else
                        raise_error(c);
                end
                LX_SYMBOL:
                begin
                    if (is_word_char(c))
                    begin
                        add_char(c);
                        taken = 1'b1;
                    end
                    else
                        lx_state = LX_COMPLETE;
                end
                default:
                    lx_state = LX_NEW;
            endcase
        end
    endfunction

    function automatic void predict_item(item_t it);
        logic [4:0] tt;
        int         i;
        step_count = 0;
        if (!halted)
        begin
            if (it.end_of_input)
            begin
                tt = (tok_type == TT_UNKNOWN && !tok_nonempty) ? TT_END : tok_type;
                close_token(tt);
                clear_lexer();
            end
            else if (it.char_in != CH_NUL)
                lex_byte(it.char_in);
        end
        if (step_count > 0)
            step_buf[step_count - 1].last_of_run = 1'b1;
        for (i = 0; i < step_count; i++)
            due_results.push_back(step_buf[i]);
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] seen);
        if (want !== seen)
        begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, seen);
            mismatches++;
        end
    endfunction

    function automatic void check_result(result_t got);
        result_t want;
        if (due_results.size() == 0)
        begin
            $display("%0t ns: unexpected result, got kind %0d char %0d type %0d last %0d",
                     $time, got.event_kind, got.char_out, got.token_type, got.last_of_run);
            mismatches++;
        end
        else
        begin
            want = due_results.pop_front();
            check_field("event_kind", 8'(want.event_kind), 8'(got.event_kind));
            check_field("char_out", want.char_out, got.char_out);
            check_field("token_type", 8'(want.token_type), 8'(got.token_type));
            check_field("last_of_run", 8'(want.last_of_run), 8'(got.last_of_run));
        end
    endfunction

    // pop side first: a result leaving now belongs to an earlier transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_lexer();
            due_results.delete();
        end
        else
        begin
            if (pop && !empty)
                check_result(result);
            if (push && !full)
                predict_item(item);
        end
        outstanding = due_results.size();
    end

endmodule

// File: sim/tb_top.sv
// Testbench top of the source tokenizer: clock, reset, byte stimulus, pop pacing, verdict.
`timescale 1ns / 100ps

module tb_top;

    import hst_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 2;
    localparam int RANDOM_ITEMS = 1800;
    // worst case is roughly two results per byte, each sitting out a long pop stall
    localparam int CYCLE_LIMIT  = 600000;
    // spare cycles after the last expected result, to catch stray results
    localparam int DRAIN_CYCLES = 8;

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;
    logic        push  = 1'b0;
    logic        pop   = 1'b0;
    item_t       item  = '0;
    logic        full;
    logic        empty;
    result_t     result;

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned cycle_count = 0;
    int unsigned sent_items  = 0;

    // calm_*: stretches with no idling on that side
    logic        calm_in  = 1'b0;
    logic        calm_out = 1'b0;
    // lexer is inside a symbol, so a new word would merge with it
    logic        in_word  = 1'b0;

    hdl_source_tokenizer_core i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    token_stream_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .item        (item),
        .empty       (empty),
        .pop         (pop),
        .result      (result),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Single reset at the start of the run, released on a rising edge.
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Hard stop if the block hangs or starves either channel.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then a long one.
    function automatic int gap_len(logic calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic logic [7:0] word_char();
        int idx;
        idx = $urandom_range(0, 61);
        if (idx < 10)
            return 8'(CH_0 + idx);
        if (idx < 36)
            return 8'(CH_UA + (idx - 10));
        return 8'(CH_LA + (idx - 36));
    endfunction

    function automatic logic [7:0] space_char();
        case ($urandom_range(0, 5))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_NL;
            3:       return CH_VT;
            4:       return CH_FF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] punct_char();
        case ($urandom_range(0, 9))
            0:       return CH_LPAR;
            1:       return CH_RPAR;
            2:       return CH_LBRC;
            3:       return CH_RBRC;
            4:       return CH_LBRK;
            5:       return CH_RBRK;
            6:       return CH_COMMA;
            7:       return CH_EQ;
            8:       return CH_COLON;
            default: return CH_SEMI;
        endcase
    endfunction

    function automatic string keyword_text(int k);
        case (k)
            0:       return "CHIP";
            1:       return "IN";
            2:       return "OUT";
            default: return "PARTS";
        endcase
    endfunction

    // One transfer on the input side. push stays high into the next item
    // when no gap follows, so it is never lowered and raised in one step.
    task automatic send_item(logic [7:0] c, logic eoi);
        item_t it;
        int    n;
        it.char_in      = c;
        it.end_of_input = eoi;
        push <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (full);
        // zero bytes are dropped by the block and do not count
        if (eoi || c != CH_NUL)
        begin
            sent_items++;
            if (sent_items % 128 == 0)
                calm_in = ($urandom_range(0, 3) == 0);
        end
        n = gap_len(calm_in);
        if (n > 0)
        begin
            push <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic put_byte(logic [7:0] c);
        send_item(c, 1'b0);
    endtask

    task automatic put_end(logic [7:0] c);
        send_item(c, 1'b1);
    endtask

    // a stray zero byte now and then; the lexer must not notice it
    task automatic feed(logic [7:0] c);
        if ($urandom_range(0, 31) == 0)
            put_byte(CH_NUL);
        put_byte(c);
    endtask

    task automatic feed_text(string s, logic noisy);
        int i;
        for (i = 0; i < s.len(); i++)
        begin
            if (noisy)
                feed(s[i]);
            else
                put_byte(s[i]);
        end
    endtask

    // Leading letters of a keyword, stopping short of the last one. Inside a
    // symbol they would merge and a later odd byte would then end the symbol
    // and reach the new-token state, so a space closes the symbol first.
    task automatic feed_prefix();
        string s;
        int    k;
        int    i;
        if (in_word)
            feed(CH_SPACE);
        s = keyword_text($urandom_range(0, 3));
        k = $urandom_range(1, s.len() - 1);
        for (i = 0; i < k; i++)
            feed(s[i]);
    endtask

    // Block comment whose body never closes it early. A star right after a
    // star does not arm the close, so the body tracks whether it is armed.
    task automatic feed_block_comment();
        logic [7:0] c;
        logic       armed;
        int         n;
        feed(CH_SLASH);
        feed(CH_STAR);
        armed = 1'b0;
        n     = $urandom_range(0, 14);
        repeat (n)
        begin
            c = ($urandom_range(0, 3) == 0) ? CH_STAR : any_byte();
            if (armed && c == CH_SLASH)
                c = CH_STAR;
            armed = armed ? 1'b0 : (c == CH_STAR);
            feed(c);
        end
        if (armed)
            feed(CH_SPACE);
        feed(CH_STAR);
        feed(CH_SLASH);
    endtask

    // Line comment: any bytes but newline, closed by newline or end of input.
    task automatic feed_line_comment();
        logic [7:0] c;
        int         n;
        feed(CH_SLASH);
        feed(CH_SLASH);
        n = $urandom_range(0, 12);
        repeat (n)
        begin
            c = any_byte();
            if (c == CH_NL)
                c = CH_SPACE;
            feed(c);
        end
        if ($urandom_range(0, 5) == 0)
            put_end(8'($urandom_range(0, 255)));
        else
            feed(CH_NL);
    endtask

    // Token left half done and cut off by end of input.
    task automatic feed_broken();
        logic [7:0] c;
        int         n;
        case ($urandom_range(0, 3))
            0: feed(CH_SLASH);
            1: feed(CH_DOT);
            2:
            begin
                feed(CH_SLASH);
                feed(CH_STAR);
                n = $urandom_range(0, 5);
                repeat (n)
                begin
                    c = any_byte();
                    if (c == CH_STAR)
                        c = CH_SPACE;
                    feed(c);
                end
            end
            default: feed_prefix();
        endcase
        put_end(8'($urandom_range(0, 255)));
    endtask

    // One well-formed token with random content, or now and then an end of input.
    task automatic feed_token();
        logic [7:0] c;
        int         pick;
        int         n;
        pick = $urandom_range(0, 99);
        if (pick < 14)
        begin
            n = $urandom_range(1, 4);
            repeat (n) feed(space_char());
            in_word = 1'b0;
        end
        else if (pick < 22)
        begin
            feed_line_comment();
            in_word = 1'b0;
        end
        else if (pick < 30)
        begin
            feed_block_comment();
            in_word = 1'b0;
        end
        else if (pick < 42)
        begin
            // inside a symbol the keyword just extends it, so in_word holds
            feed_text(keyword_text($urandom_range(0, 3)), 1'b1);
        end
        else if (pick < 54)
        begin
            // after a keyword prefix any byte is taken into a symbol
            feed_prefix();
            do
                c = any_byte();
            while (c >= CH_UA && c <= CH_UZ);
            feed(c);
            in_word = 1'b1;
        end
        else if (pick < 68)
        begin
            do
                c = word_char();
            while (c == CH_UC || c == CH_UI || c == CH_UO || c == CH_UP);
            feed(c);
            n = $urandom_range(0, 6);
            repeat (n) feed(word_char());
            in_word = 1'b1;
        end
        else if (pick < 76)
        begin
            feed(CH_DOT);
            feed(CH_DOT);
            in_word = 1'b0;
        end
        else if (pick < 92)
        begin
            feed(punct_char());
            in_word = 1'b0;
        end
        else if (pick < 96)
        begin
            feed_broken();
            in_word = 1'b0;
        end
        else
        begin
            put_end(8'($urandom_range(0, 255)));
            in_word = 1'b0;
        end
    endtask

    // Pop side: runs of pops broken by random stalls, for the whole run.
    initial
    begin : result_side
        int n;
        wait (rst_n === 1'b1);
        forever
        begin
            pop <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            n = gap_len(calm_out);
            if (n > 0)
            begin
                pop <= 1'b0;
                repeat (n) @(posedge clk);
            end
            if ($urandom_range(0, 15) == 0)
                calm_out = ($urandom_range(0, 3) == 0);
        end
    end

    // Input side and verdict.
    initial
    begin : byte_side
        logic [7:0] c;
        wait (rst_n === 1'b1);

        // Directed: keyword closed early then a symbol, an ignored zero byte,
        // whitespace closing a symbol, range, punctuation, a block comment
        // whose close is delayed by a doubled star, a prefix taking a high
        // byte, end on a symbol, end on nothing, end on a lone dot.
        feed_text("CHIPX", 1'b0);
        put_byte(CH_NUL);
        put_byte(CH_TAB);
        feed_text("..;/***/*/", 1'b0);
        put_byte(CH_UP);
        put_byte(8'h80);
        put_end(8'hFF);
        put_end(CH_NUL);
        put_byte(CH_DOT);
        put_end(CH_UZ);

        // Random: mostly well-formed source with random content.
        sent_items = 0;
        in_word    = 1'b0;
        while (sent_items < RANDOM_ITEMS)
            feed_token();

        // Syntax error last of all, as it halts the block for good. Whatever
        // follows, end of input included, must give nothing.
        put_end(8'($urandom_range(0, 255)));
        case ($urandom_range(0, 2))
            0:
            begin
                put_byte(CH_LPAR);
                put_byte(8'($urandom_range(128, 255)));
            end
            1:
            begin
                put_byte(CH_SLASH);
                do
                    c = any_byte();
                while (c == CH_SLASH || c == CH_STAR);
                put_byte(c);
            end
            default:
            begin
                put_byte(CH_DOT);
                do
                    c = any_byte();
                while (c == CH_DOT);
                put_byte(c);
            end
        endcase
        repeat (16)
        begin
            if ($urandom_range(0, 3) == 0)
                put_end(8'($urandom_range(0, 255)));
            else
                put_byte(8'($urandom_range(0, 255)));
        end
        push <= 1'b0;

        // Let every expected transfer arrive, then watch for strays.
        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (outstanding != 0)
            $display("%0d expected results never arrived", outstanding);
        if (mismatches == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
